// ----- hdl/sld_pkg.sv -----
// Shared types and constants of the serial line discipline.
package sld_pkg;

  localparam int SLD_LINE_CAP   = 32;
  localparam int SLD_QUEUE_DEPTH = 2;
  localparam int CFG_INDEX_W    = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_LINE_MODE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ECHO_ENABLE = 2'd1;

  localparam logic [7:0] CH_DEL = 8'h7f;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_CR  = 8'h0d;
  localparam logic [7:0] CH_LF  = 8'h0a;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_SUB = 8'h1a;

  localparam logic TARGET_RX   = 1'b0;
  localparam logic TARGET_ECHO = 1'b1;

  typedef enum logic [1:0] {
    ECHO_NONE,
    ECHO_ONE,
    ECHO_LF,
    ECHO_ERASE
  } echo_kind_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_RAW,
    B_FETCH,
    B_SEND,
    B_ECHO
  } back_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       wr_en;
    logic       flush;
    logic       raw;
    echo_kind_t echo;
  } cmd_t;

endpackage

// ----- hdl/sld_front.sv -----
// Front end: configuration registers, line bookkeeping and command classification.
module sld_front
  import sld_pkg::*;
#(
  parameter int LINE_CAP = SLD_LINE_CAP,
  localparam int LW = (LINE_CAP > 2) ? $clog2(LINE_CAP) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic                   cfg_data,
  input  logic                   in_valid,
  input  logic [7:0]             in_byte,
  input  logic                   in_buffer_ready,
  input  logic                   q_full,
  output logic                   in_ready,
  output logic                   q_push,
  output cmd_t                   q_cmd,
  output logic [LW-1:0]          q_addr
);

  logic          line_mode_r;
  logic          echo_enable_r;
  logic [LW-1:0] line_len_r, line_len_nxt;
  logic          line_open_r, line_open_nxt;
  logic [LW-1:0] len_eff;
  logic          accept;
  logic          drop;
  logic          is_term;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign len_eff  = line_open_r ? line_len_r : '0;
  assign is_term  = (in_byte == CH_EOT) || (in_byte == CH_ETX) || (in_byte == CH_LF) ||
                    (in_byte == CH_SUB) || (in_byte == CH_CR);

  always_comb begin
    drop          = line_mode_r ? (!line_open_r && !in_buffer_ready) : !in_buffer_ready;
    line_len_nxt  = line_len_r;
    line_open_nxt = line_open_r;
    q_addr        = len_eff;
    q_cmd.data    = in_byte;
    q_cmd.wr_en   = 1'b0;
    q_cmd.flush   = 1'b0;
    q_cmd.raw     = 1'b0;
    if (!echo_enable_r) begin
      q_cmd.echo = ECHO_NONE;
    end else if ((in_byte == CH_BS) || (in_byte == CH_DEL)) begin
      q_cmd.echo = ECHO_ERASE;
    end else if (in_byte == CH_LF) begin
      q_cmd.echo = ECHO_LF;
    end else begin
      q_cmd.echo = ECHO_ONE;
    end
    if (!line_mode_r) begin
      q_cmd.raw = 1'b1;
    end else if (is_term || (len_eff >= LW'(LINE_CAP - 1))) begin
      q_cmd.wr_en   = 1'b1;
      q_cmd.flush   = 1'b1;
      line_len_nxt  = '0;
      line_open_nxt = 1'b0;
    end else if ((in_byte == CH_DEL) && (len_eff != '0)) begin
      line_len_nxt  = len_eff - LW'(1);
      line_open_nxt = 1'b1;
    end else begin
      q_cmd.wr_en   = 1'b1;
      line_len_nxt  = len_eff + LW'(1);
      line_open_nxt = 1'b1;
    end
    q_push = accept && !drop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_mode_r   <= 1'b1;
      echo_enable_r <= 1'b1;
    end else if (cfg_valid) begin
      if (cfg_index == REG_LINE_MODE) begin
        line_mode_r <= cfg_data;
      end else if (cfg_index == REG_ECHO_ENABLE) begin
        echo_enable_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_len_r  <= '0;
      line_open_r <= 1'b0;
    end else if (q_push) begin
      line_len_r  <= line_len_nxt;
      line_open_r <= line_open_nxt;
    end
  end

endmodule

// ----- hdl/sld_cmd_fifo.sv -----
// Short command queue between the front end and the back end.
module sld_cmd_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         full,
  output logic         not_empty
);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

// ----- hdl/sld_back.sv -----
// Back end: line store, line flush sequencing, echo generation and output register.
module sld_back
  import sld_pkg::*;
#(
  parameter int LINE_CAP = SLD_LINE_CAP,
  localparam int LW = (LINE_CAP > 2) ? $clog2(LINE_CAP) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  cmd_t          q_cmd,
  input  logic [LW-1:0] q_addr,
  output logic          q_pop,
  input  logic          out_ready,
  output logic          out_valid,
  output logic          out_target,
  output logic [7:0]    out_byte,
  output logic          out_end,
  output logic          out_last
);

  logic [7:0]    line_mem [LINE_CAP];
  logic [7:0]    rd_data_r;
  back_state_t   state_r, state_nxt;
  cmd_t          cur_r;
  logic [LW-1:0] last_r, idx_r, idx_nxt;
  logic [1:0]    ecnt_r, ecnt_nxt;
  logic          out_valid_r, out_target_r, out_end_r, out_last_r;
  logic [7:0]    out_byte_r;
  logic          slot_free;
  logic          load;
  logic          ld_target, ld_end, ld_last;
  logic [7:0]    ld_byte;
  logic          mem_we, rd_en;
  logic [LW-1:0] rd_addr;
  logic          echo_last;
  logic [7:0]    echo_byte;
  logic          no_echo;

  assign slot_free = !out_valid_r || out_ready;
  assign no_echo   = (cur_r.echo == ECHO_NONE);

  always_comb begin
    unique case (cur_r.echo)
      ECHO_LF: begin
        echo_byte = (ecnt_r == 2'd0) ? CH_LF : CH_CR;
        echo_last = (ecnt_r == 2'd1);
      end
      ECHO_ERASE: begin
        echo_byte = (ecnt_r == 2'd1) ? CH_SP : CH_BS;
        echo_last = (ecnt_r == 2'd2);
      end
      default: begin
        echo_byte = {1'b0, cur_r.data[6:0]};
        echo_last = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    ecnt_nxt  = ecnt_r;
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = idx_r;
    load      = 1'b0;
    ld_target = TARGET_RX;
    ld_byte   = cur_r.data;
    ld_end    = 1'b0;
    ld_last   = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        ecnt_nxt = 2'd0;
        if (q_valid) begin
          q_pop  = 1'b1;
          mem_we = q_cmd.wr_en;
          if (q_cmd.raw) begin
            state_nxt = B_RAW;
          end else if (q_cmd.flush) begin
            state_nxt = B_FETCH;
          end else if (q_cmd.echo != ECHO_NONE) begin
            state_nxt = B_ECHO;
          end
        end
      end
      B_RAW: begin
        if (slot_free) begin
          load      = 1'b1;
          ld_end    = 1'b1;
          ld_last   = no_echo;
          state_nxt = no_echo ? B_IDLE : B_ECHO;
        end
      end
      B_FETCH: begin
        rd_en     = 1'b1;
        rd_addr   = '0;
        idx_nxt   = '0;
        state_nxt = B_SEND;
      end
      B_SEND: begin
        if (slot_free) begin
          load    = 1'b1;
          ld_byte = rd_data_r;
          ld_end  = (idx_r == last_r);
          ld_last = (idx_r == last_r) && no_echo;
          if (idx_r == last_r) begin
            state_nxt = no_echo ? B_IDLE : B_ECHO;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_r + LW'(1);
            idx_nxt = idx_r + LW'(1);
          end
        end
      end
      B_ECHO: begin
        if (slot_free) begin
          load      = 1'b1;
          ld_target = TARGET_ECHO;
          ld_byte   = echo_byte;
          ld_last   = echo_last;
          if (echo_last) begin
            state_nxt = B_IDLE;
          end else begin
            ecnt_nxt = ecnt_r + 2'd1;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[q_addr] <= q_cmd.data;
    end
    if (rd_en) begin
      rd_data_r <= line_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r  <= q_cmd;
      last_r <= q_addr;
    end
    idx_r  <= idx_nxt;
    ecnt_r <= ecnt_nxt;
    if (load) begin
      out_target_r <= ld_target;
      out_byte_r   <= ld_byte;
      out_end_r    <= ld_end;
      out_last_r   <= ld_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_target = out_target_r;
  assign out_byte   = out_byte_r;
  assign out_end    = out_end_r;
  assign out_last   = out_last_r;

endmodule

// ----- hdl/serial_line_discipline.sv -----
// Top level of the serial receive line discipline with line editing and echo.
// Each received byte is classified and, unless it is dropped because no buffer is ready,
// queued; the back end takes a command from the queue while idle and then emits its
// results one per cycle from an output register while the output is not stalled. A raw
// byte gives one result, a line flush first starts the line store read and then sends
// each stored byte, and echo adds one to three results. The longest case is a DEL or BS
// that flushes a full line with echo on: LINE_CAP stored bytes followed by three echo
// bytes. The single read port of the line store sets the flush rate. A command queue
// of two entries lets the input keep accepting bytes while a flush or echo is still
// being sent.
module serial_line_discipline
  import sld_pkg::*;
#(
  parameter int LINE_CAP = SLD_LINE_CAP
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic                   cfg_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,  // [7:0] rx_byte
  input  logic                   in_tuser,  // [0] buffer_ready
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [15:0]            out_tdata, // [7:0] out_byte, [8] buffer_end, rest zero
  output logic                   out_tuser, // [0] target
  output logic                   out_tlast  // run_last
);

  localparam int LW = (LINE_CAP > 2) ? $clog2(LINE_CAP) : 1;
  localparam int QW = $bits(cmd_t) + LW;

  logic          q_push, q_pop, q_full, q_not_empty;
  cmd_t          f_cmd, b_cmd;
  logic [LW-1:0] f_addr, b_addr;
  logic [QW-1:0] q_out;
  logic [7:0]    o_byte;
  logic          o_end;

  assign cfg_ready = 1'b1;

  sld_front #(.LINE_CAP(LINE_CAP)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_tvalid),
    .in_byte         (in_tdata),
    .in_buffer_ready (in_tuser),
    .q_full          (q_full),
    .in_ready        (in_tready),
    .q_push          (q_push),
    .q_cmd           (f_cmd),
    .q_addr          (f_addr)
  );

  sld_cmd_fifo #(.W(QW), .DEPTH(SLD_QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_cmd, f_addr}),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  assign b_cmd  = q_out[QW-1:LW];
  assign b_addr = q_out[LW-1:0];

  sld_back #(.LINE_CAP(LINE_CAP)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_not_empty),
    .q_cmd      (b_cmd),
    .q_addr     (b_addr),
    .q_pop      (q_pop),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_target (out_tuser),
    .out_byte   (o_byte),
    .out_end    (o_end),
    .out_last   (out_tlast)
  );

  assign out_tdata = {7'd0, o_end, o_byte};

endmodule

// ----- sim/serial_line_discipline_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the serial line discipline: edited lines, raw bytes and echo.
module serial_line_discipline_test;
  import sld_pkg::*;

  localparam int LINE_CAP = SLD_LINE_CAP;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = LINE_CAP + 20;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct {
    logic       target;
    logic [7:0] data;
    logic       buf_end;
    logic       last;
  } beat_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic                   cfg_data = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = '0;   // [7:0] rx_byte
  logic                   in_tuser = 1'b0; // [0] buffer_ready
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [15:0]            out_tdata;       // [7:0] out_byte, [8] buffer_end, rest zero
  logic                   out_tuser;       // [0] target
  logic                   out_tlast;

  logic [7:0] line_buf [LINE_CAP];
  int         line_len = 0;
  bit         line_held = 1'b0;
  bit         mode_line = 1'b1;
  bit         echo_on = 1'b1;
  beat_t      pending_beats[$];
  int         errors = 0;
  int         sent_count = 0;
  logic       calm = 1'b0;
  logic       hold_go = 1'b0;
  int         hold_count = 0;

  serial_line_discipline u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #1 clk = ~clk;

  function automatic bit is_term(logic [7:0] b);
    return b == CH_EOT || b == CH_ETX || b == CH_LF || b == CH_SUB || b == CH_CR;
  endfunction

  // Updates the line state for one accepted byte and queues the results it causes.
  function automatic void discipline_step(logic [7:0] b, logic rdy);
    beat_t run[$];
    if (!mode_line) begin
      if (!rdy) return;
      run.push_back(beat_t'{TARGET_RX, b, 1'b1, 1'b0});
    end else begin
      if (!line_held) begin
        if (!rdy) return;
        line_held = 1'b1;
        line_len = 0;
      end
      if (line_len >= LINE_CAP - 1 || is_term(b)) begin
        line_buf[line_len] = b;
        line_len++;
        for (int i = 0; i < line_len; i++)
          run.push_back(beat_t'{TARGET_RX, line_buf[i], (i + 1 == line_len), 1'b0});
        line_held = 1'b0;
        line_len = 0;
      end else if (b == CH_DEL && line_len > 0) begin
        line_len--;
      end else begin
        line_buf[line_len] = b;
        line_len++;
      end
    end
    if (echo_on) begin
      if (b == CH_BS || b == CH_DEL) begin
        run.push_back(beat_t'{TARGET_ECHO, CH_BS, 1'b0, 1'b0});
        run.push_back(beat_t'{TARGET_ECHO, CH_SP, 1'b0, 1'b0});
        run.push_back(beat_t'{TARGET_ECHO, CH_BS, 1'b0, 1'b0});
      end else begin
        run.push_back(beat_t'{TARGET_ECHO, {1'b0, b[6:0]}, 1'b0, 1'b0});
        if (b == CH_LF) run.push_back(beat_t'{TARGET_ECHO, CH_CR, 1'b0, 1'b0});
      end
    end
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
    foreach (run[i]) pending_beats.push_back(run[i]);
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual byte %h target %b",
                 $time, out_tdata[7:0], out_tuser);
      end else begin
        want = pending_beats.pop_front();
        check_field("target", {7'b0, want.target}, {7'b0, out_tuser});
        check_field("out_byte", want.data, out_tdata[7:0]);
        check_field("buffer_end", {7'b0, want.buf_end}, {7'b0, out_tdata[8]});
        check_field("run_last", {7'b0, want.last}, {7'b0, out_tlast});
        check_field("tdata padding", 8'h00, {1'b0, out_tdata[15:9]});
      end
    end
  end

  // Receiver: random stalls, a calm stretch, and one long hold-off on request.
  always @(posedge clk) begin
    if (hold_go && hold_count < HOLD_CYCLES) begin
      out_tready <= 1'b0;
      hold_count <= hold_count + 1;
    end else if (calm) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 24);
    end
  end

  task automatic send_rx(input logic [7:0] b, input logic rdy);
    if (!calm && $urandom_range(99) < 24) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= rdy;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    discipline_step(b, rdy);
    sent_count++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_LINE_MODE:   mode_line = d;
      REG_ECHO_ENABLE: echo_on = d;
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic line, input logic echo);
    settle();
    write_reg(REG_LINE_MODE, line);
    write_reg(REG_ECHO_ENABLE, echo);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] content_byte();
    int r;
    logic [7:0] b;
    r = $urandom_range(99);
    if (r < 8) return CH_DEL;
    if (r < 13) return CH_BS;
    b = 8'($urandom_range(255));
    if (is_term(b)) b = CH_SP;
    return b;
  endfunction

  function automatic logic [7:0] term_byte();
    case ($urandom_range(4))
      0: return CH_EOT;
      1: return CH_ETX;
      2: return CH_LF;
      3: return CH_SUB;
      default: return CH_CR;
    endcase
  endfunction

  task automatic send_line(input int len);
    for (int i = 0; i < len; i++)
      send_rx(content_byte(), (i == 0) ? 1'b1 : ($urandom_range(9) != 0));
    send_rx(term_byte(), (len == 0) ? 1'b1 : ($urandom_range(3) != 0));
  endtask

  task automatic test_reset_line();
    send_rx(8'h6f, 1'b1);
    send_rx(8'h6b, 1'b1);
    send_rx(CH_CR, 1'b1);
    send_rx(8'h61, 1'b1);
    send_rx(8'h62, 1'b1);
    send_rx(CH_DEL, 1'b1);
    send_rx(CH_LF, 1'b1);
  endtask

  task automatic test_no_buffer();
    send_rx(8'h78, 1'b0);
    send_rx(8'h79, 1'b1);
    send_rx(8'h7a, 1'b0);
    send_rx(CH_ETX, 1'b0);
  endtask

  task automatic test_edit_and_echo();
    send_rx(CH_DEL, 1'b1);
    send_rx(CH_BS, 1'b1);
    send_rx(8'hff, 1'b1);
    send_rx(8'h00, 1'b1);
    send_rx(8'h80, 1'b1);
    send_rx(CH_EOT, 1'b1);
    send_rx(CH_SUB, 1'b1);
  endtask

  task automatic test_registers();
    set_regs(1'b0, 1'b1);
    send_rx(8'hff, 1'b1);
    send_rx(8'h00, 1'b0);
    send_rx(CH_LF, 1'b1);
    send_rx(CH_DEL, 1'b1);
    settle();
    write_reg(REG_SPARE_2, 1'b1);
    write_reg(REG_SPARE_3, 1'b0);
    cfg_valid <= 1'b0;
    send_rx(8'h55, 1'b1);
    set_regs(1'b1, 1'b0);
    send_rx(8'h71, 1'b1);
    send_rx(CH_CR, 1'b1);
  endtask

  task automatic test_mode_switch();
    set_regs(1'b1, 1'b1);
    send_rx(8'h61, 1'b1);
    send_rx(8'h62, 1'b1);
    set_regs(1'b0, 1'b1);
    send_rx(8'h72, 1'b1);
    set_regs(1'b1, 1'b1);
    send_rx(8'h63, 1'b0);
    send_rx(CH_CR, 1'b0);
  endtask

  task automatic test_hold_off();
    set_regs(1'b1, 1'b1);
    calm <= 1'b1;
    hold_go <= 1'b1;
    for (int i = 0; i < 40; i++) send_rx(8'h30 + 8'(i % 10), 1'b1);
    send_rx(CH_CR, 1'b1);
    calm <= 1'b0;
  endtask

  task automatic test_random();
    int stop_at;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0, 4: set_regs(1'b1, 1'b1);
        1:    set_regs(1'b1, 1'b0);
        2:    set_regs(1'b0, 1'b1);
        3:    set_regs(1'b0, 1'b0);
        default: set_regs(1'b1, 1'b0);
      endcase
      calm <= (p == 4);
      stop_at = sent_count + 20;
      while (sent_count < stop_at) begin
        if ($urandom_range(99) < 75)
          send_line(($urandom_range(4) == 0) ? $urandom_range(25, 40) : $urandom_range(0, 12));
        else
          send_rx(8'($urandom_range(255)), 1'($urandom_range(1)));
      end
      calm <= 1'b0;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_line();
    test_no_buffer();
    test_edit_and_echo();
    test_registers();
    test_mode_switch();
    test_hold_off();
    test_random();
    settle();
    if (errors == 0)
      $display("** serial_line_discipline: PASSED **");
    else
      $display("** serial_line_discipline: FAILED **");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("** serial_line_discipline: FAILED **");
    $finish;
  end

endmodule
